// File: rtl/core/pidt_pkg.sv
package pidt_pkg;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_INC,
		ST_PMUL,
		ST_IMUL,
		ST_DWAIT,
		ST_DMUL,
		ST_FIN
	} ctrl_state_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_UPDATED = 2'd0,
		STAT_HELD    = 2'd1,
		STAT_CLEARED = 2'd2
	} step_status_t;

	// operand selection for the shared multiplier
	typedef enum logic [1:0] {
		MUL_INC,
		MUL_P,
		MUL_I,
		MUL_D
	} mul_sel_t;

	// register indexes on the config port
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_P_GAIN = 2'd0;
	localparam reg_idx_t REG_I_GAIN = 2'd1;
	localparam reg_idx_t REG_D_GAIN = 2'd2;

	// multiplier digit width, bits of the second operand per cycle
	localparam int MUL_DIGIT = 16;

	// commands from controller to datapath
	typedef struct packed {
		logic         accept;
		logic         start_div;
		logic         start_mul;
		mul_sel_t     mul_sel;
		logic         acc_upd;
		logic         clr_sum;
		logic         add_sum;
		logic         load_out;
		step_status_t kind;
	} pidt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic t_lt;
		logic t_eq;
		logic div_busy;
		logic mul_busy;
	} pidt_stat_t;

endpackage

// File: rtl/core/pid_controller_trapezoid.sv
// PID controller with trapezoidal integration, signed Q16.16 at the defaults.
// Input channel (in_valid / in_stall) carries one word per control step: an
// error sample and an unsigned time stamp. Output channel (out_valid /
// out_stall) returns one word per input word: the drive value, a status code
// (updated, held for an equal stamp, cleared by a backward stamp) and a clip
// flag. Gains are written over the APB port; the user must do so only while
// the block is idle, the block itself does not enforce it. Held and cleared
// words pass from the evaluate state through the finish state to the output
// register. An updated word waits on the derivative divider, which produces one
// quotient bit per cycle; the shared 16-bit-digit multiplier runs the integral
// update and two of the three gain products in its shadow.
// One word is in flight at a time; in_stall is low whenever the controller is
// idle, even while a finished word still waits on the output register.
// The next word is taken the cycle after a result loads; no word is taken while
// the controller is still working on the last one.
// A stalled output word holds; a finished word waits until the register frees.
// Reset clears the integral, the previous sample, stamp and held drive, sets
// p_gain to 1.0 and the other gains to zero, and drops out_valid.
module pid_controller_trapezoid #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int ACC_WIDTH  = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [((DATA_WIDTH > 32) ? 5 : 4)-1:0]  paddr,
	input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [DATA_WIDTH-1:0]          sample_value,
	input  logic [DATA_WIDTH-1:0]                 time_stamp,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [DATA_WIDTH-1:0]          drive_value,
	output logic [1:0]                            step_status,
	output logic                                  saturated
);
	import pidt_pkg::*;

	localparam int PDW = (DATA_WIDTH > 32) ? 64 : 32;
	localparam int PAW = (DATA_WIDTH > 32) ? 5 : 4;
	localparam int ASH = (DATA_WIDTH > 32) ? 3 : 2;

	logic [DATA_WIDTH-1:0] p_gain_q;
	logic [DATA_WIDTH-1:0] i_gain_q;
	logic [DATA_WIDTH-1:0] d_gain_q;
	reg_idx_t              reg_idx;
	logic                  reg_wr;
	logic [DATA_WIDTH-1:0] drive_w;

	pidt_cmd_t  cmd;
	pidt_stat_t stat;

	assign reg_idx = paddr[PAW-1:ASH];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q <= DATA_WIDTH'(1) << FRAC_BITS;
			i_gain_q <= '0;
			d_gain_q <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_P_GAIN: p_gain_q <= pwdata[DATA_WIDTH-1:0];
				REG_I_GAIN: i_gain_q <= pwdata[DATA_WIDTH-1:0];
				REG_D_GAIN: d_gain_q <= pwdata[DATA_WIDTH-1:0];
				default: begin
					p_gain_q <= p_gain_q;
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_P_GAIN: prdata = PDW'($signed(p_gain_q));
			REG_I_GAIN: prdata = PDW'($signed(i_gain_q));
			REG_D_GAIN: prdata = PDW'($signed(d_gain_q));
			default:    prdata = '0;
		endcase
	end

	pidt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	pidt_dp #(
		.W(DATA_WIDTH),
		.F(FRAC_BITS),
		.A(ACC_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (sample_value),
		.time_stamp   (time_stamp),
		.p_gain       (p_gain_q),
		.i_gain       (i_gain_q),
		.d_gain       (d_gain_q),
		.cmd          (cmd),
		.stat         (stat),
		.drive_value  (drive_w),
		.step_status  (step_status),
		.saturated    (saturated)
	);

	assign drive_value = drive_w;

endmodule

// File: rtl/core/pidt_div.sv
module pidt_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W:0]   num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] quo
);
	import pidt_pkg::*;

	localparam int NI = W + F + 1;
	localparam int NW = W + 1 + F;
	localparam int CW = $clog2(NI);
	localparam logic [CW-1:0] LAST = CW'(NI - 1);
	// quotient clamp, sticky once reached
	localparam logic [W:0] CAP = {2'b01, {(W-2){1'b0}}, 1'b1};

	logic [NW-1:0] nsh_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [W:0]   r1;
	logic [W:0]   r_sub;
	logic         ge;
	logic [W-1:0] rem_next;
	logic [W:0]   qs;
	logic [W-1:0] q_next;

	// one restoring step per cycle
	always_comb begin
		r1       = {rem_q, nsh_q[NW-1]};
		ge       = (r1 >= {1'b0, den_q});
		r_sub    = r1 - {1'b0, den_q};
		rem_next = ge ? r_sub[W-1:0] : r1[W-1:0];
		qs       = {q_q, ge};
		q_next   = (qs > CAP) ? CAP[W-1:0] : qs[W-1:0];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend shift, remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			nsh_q <= {num, {F{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			nsh_q <= nsh_q << 1;
			rem_q <= rem_next;
			q_q   <= q_next;
		end
	end

	assign busy = busy_q;
	assign quo  = q_q;

endmodule

// File: rtl/core/pidt_mul.sv
module pidt_mul #(
	parameter int AW = 65,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	input  logic             neg,
	output logic             busy,
	output logic [AW+BW-1:0] mag,
	output logic             mag_neg
);
	import pidt_pkg::*;

	localparam int D   = MUL_DIGIT;
	localparam int ND  = (BW + D - 1) / D;
	localparam int BPW = ND * D;
	localparam int PW  = AW + BW;
	localparam int CW  = (ND > 1) ? $clog2(ND) : 1;
	localparam logic [CW-1:0] LAST = CW'(ND - 1);

	logic [AW-1:0]  a_q;
	logic [BPW-1:0] b_q;
	logic [PW-1:0]  p_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;

	logic [D-1:0]    digit;
	logic [AW+D-1:0] pp;
	logic [PW-1:0]   p_next;

	// most significant digit first, shift and add
	always_comb begin
		digit  = b_q[BPW-1 -: D];
		pp     = a_q * digit;
		p_next = (p_q << D) + PW'(pp);
	end

	// digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operands and partial sum
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BPW'(b);
			p_q   <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			b_q <= b_q << D;
			p_q <= p_next;
		end
	end

	assign busy    = busy_q;
	assign mag     = p_q;
	assign mag_neg = neg_q;

endmodule

// File: rtl/core/pidt_ctrl.sv
module pidt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output pidt_pkg::pidt_cmd_t cmd,
	input  pidt_pkg::pidt_stat_t stat
);
	import pidt_pkg::*;

	ctrl_state_t  state_q;
	ctrl_state_t  state_d;
	step_status_t kind_q;
	logic         out_valid_q;
	logic         out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.t_lt || stat.t_eq) state_d = ST_FIN;
				else state_d = ST_INC;
			end
			ST_INC: begin
				if (!stat.mul_busy) state_d = ST_PMUL;
			end
			ST_PMUL: begin
				if (!stat.mul_busy) state_d = ST_IMUL;
			end
			ST_IMUL: begin
				if (!stat.mul_busy) state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (!stat.div_busy) state_d = ST_DMUL;
			end
			ST_DMUL: begin
				if (!stat.mul_busy) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_INC;
		cmd.kind    = kind_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_EVAL: begin
				cmd.clr_sum = 1'b1;
				if (!stat.t_lt && !stat.t_eq) begin
					cmd.start_div = 1'b1;
					cmd.start_mul = 1'b1;
					cmd.mul_sel   = MUL_INC;
				end
			end
			ST_INC: begin
				if (!stat.mul_busy) begin
					cmd.acc_upd   = 1'b1;
					cmd.start_mul = 1'b1;
					cmd.mul_sel   = MUL_P;
				end
			end
			ST_PMUL: begin
				if (!stat.mul_busy) begin
					cmd.add_sum   = 1'b1;
					cmd.start_mul = 1'b1;
					cmd.mul_sel   = MUL_I;
				end
			end
			ST_IMUL: begin
				if (!stat.mul_busy) cmd.add_sum = 1'b1;
			end
			ST_DWAIT: begin
				if (!stat.div_busy) begin
					cmd.start_mul = 1'b1;
					cmd.mul_sel   = MUL_D;
				end
			end
			ST_DMUL: begin
				if (!stat.mul_busy) cmd.add_sum = 1'b1;
			end
			ST_FIN: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	// state, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= STAT_UPDATED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EVAL) begin
				if (stat.t_lt) kind_q <= STAT_CLEARED;
				else if (stat.t_eq) kind_q <= STAT_HELD;
				else kind_q <= STAT_UPDATED;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/pidt_dp.sv
module pidt_dp #(
	parameter int W = 32,
	parameter int F = 16,
	parameter int A = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [W-1:0]         sample_value,
	input  logic [W-1:0]         time_stamp,
	input  logic [W-1:0]         p_gain,
	input  logic [W-1:0]         i_gain,
	input  logic [W-1:0]         d_gain,
	input  pidt_pkg::pidt_cmd_t  cmd,
	output pidt_pkg::pidt_stat_t stat,
	output logic [W-1:0]         drive_value,
	output logic [1:0]           step_status,
	output logic                 saturated
);
	import pidt_pkg::*;

	localparam int MA = (A > W + 1) ? A : W + 1;
	localparam int PW = MA + W;
	localparam int SW = PW + 3;
	localparam int EW = ((A > 64) ? A : 64) + 2;

	localparam logic [PW-1:0] INC_CAP = PW'(1) << 63;
	localparam logic [A-1:0] AMAX = {1'b0, {(A-1){1'b1}}};
	localparam logic [A-1:0] AMIN = {1'b1, {(A-1){1'b0}}};
	localparam logic signed [EW-1:0] AMAX_E = EW'({1'b0, {(A-1){1'b1}}});
	localparam logic signed [EW-1:0] AMIN_E = ~AMAX_E;
	localparam logic signed [SW-1:0] YMAX_E = SW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [SW-1:0] YMIN_E = ~YMAX_E;
	localparam logic [W-1:0] DMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] DMIN = {1'b1, {(W-1){1'b0}}};

	// input word and controller state
	logic [W-1:0] x_q;
	logic [W-1:0] t_q;
	logic [A-1:0] acc_q;
	logic [W-1:0] prev_sample_q;
	logic [W-1:0] prev_time_q;
	logic [W-1:0] held_q;

	// output sum and sticky clip flag
	logic signed [SW-1:0] s_q;
	logic                 sat_q;

	// result registers
	logic [W-1:0] drive_q;
	step_status_t status_q;
	logic         sat_out_q;

	logic [W:0]   diff;
	logic [W:0]   sum;
	logic         diff_neg;
	logic         sum_neg;
	logic [W:0]   diff_mag;
	logic [W:0]   sum_mag;
	logic [W-1:0] dt;
	logic [W-1:0] x_mag;
	logic [A-1:0] acc_mag;
	logic [W-1:0] p_mag;
	logic [W-1:0] i_mag;
	logic [W-1:0] d_mag;

	logic         div_busy;
	logic [W-1:0] quo;
	logic         deriv_sat;
	logic [W-1:0] deriv_mag;

	logic [MA-1:0] mul_a;
	logic [W-1:0]  mul_b;
	logic          mul_neg;
	logic          mul_busy;
	logic [PW-1:0] mag;
	logic          mag_neg;

	logic [PW:0]          prod_s;
	logic signed [SW-1:0] prod_e;

	logic [PW-1:0]        inc_full;
	logic                 inc_clip;
	logic [63:0]          inc64;
	logic signed [EW-1:0] acc_e;
	logic signed [EW-1:0] inc_e;
	logic signed [EW-1:0] acc_new;
	logic                 sat_hi;
	logic                 sat_lo;
	logic [A-1:0]         acc_next;

	logic signed [SW-1:0] s_sh;
	logic                 y_fit;
	logic [W-1:0]         y;

	// differences, magnitudes and elapsed time
	always_comb begin
		diff     = {x_q[W-1], x_q} - {prev_sample_q[W-1], prev_sample_q};
		sum      = {x_q[W-1], x_q} + {prev_sample_q[W-1], prev_sample_q};
		diff_neg = diff[W];
		sum_neg  = sum[W];
		diff_mag = diff_neg ? (W+1)'(0) - diff : diff;
		sum_mag  = sum_neg ? (W+1)'(0) - sum : sum;
		dt       = t_q - prev_time_q;
		x_mag    = x_q[W-1] ? W'(0) - x_q : x_q;
		acc_mag  = acc_q[A-1] ? A'(0) - acc_q : acc_q;
		p_mag    = p_gain[W-1] ? W'(0) - p_gain : p_gain;
		i_mag    = i_gain[W-1] ? W'(0) - i_gain : i_gain;
		d_mag    = d_gain[W-1] ? W'(0) - d_gain : d_gain;
	end

	assign stat.t_lt     = (t_q < prev_time_q);
	assign stat.t_eq     = (t_q == prev_time_q);
	assign stat.div_busy = div_busy;
	assign stat.mul_busy = mul_busy;

	// derivative quotient
	pidt_div #(
		.W(W),
		.F(F)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_div),
		.num    (diff_mag),
		.den    (dt),
		.busy   (div_busy),
		.quo    (quo)
	);

	// derivative clip to the signed range
	always_comb begin
		if (diff_neg) deriv_sat = quo[W-1] && (|quo[W-2:0]);
		else deriv_sat = quo[W-1];
		if (deriv_sat) deriv_mag = diff_neg ? DMIN : DMAX;
		else deriv_mag = quo;
	end

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_INC: begin
				mul_a   = MA'(sum_mag);
				mul_b   = dt;
				mul_neg = 1'b0;
			end
			MUL_P: begin
				mul_a   = MA'(x_mag);
				mul_b   = p_mag;
				mul_neg = x_q[W-1] ^ p_gain[W-1];
			end
			MUL_I: begin
				mul_a   = MA'(acc_mag);
				mul_b   = i_mag;
				mul_neg = acc_q[A-1] ^ i_gain[W-1];
			end
			MUL_D: begin
				mul_a   = MA'(deriv_mag);
				mul_b   = d_mag;
				mul_neg = diff_neg ^ d_gain[W-1];
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
	end

	pidt_mul #(
		.AW(MA),
		.BW(W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_mul),
		.a       (mul_a),
		.b       (mul_b),
		.neg     (mul_neg),
		.busy    (mul_busy),
		.mag     (mag),
		.mag_neg (mag_neg)
	);

	// signed product for the output sum
	always_comb begin
		prod_s = mag_neg ? (PW+1)'(0) - {1'b0, mag} : {1'b0, mag};
		prod_e = {{(SW-PW-1){prod_s[PW]}}, prod_s};
	end

	// trapezoid increment and saturating integral
	always_comb begin
		inc_full = mag >> (F + 1);
		inc_clip = (inc_full > INC_CAP);
		inc64    = inc_clip ? {1'b1, 63'd0} : inc_full[63:0];
		acc_e    = {{(EW-A){acc_q[A-1]}}, acc_q};
		inc_e    = {{(EW-64){1'b0}}, inc64};
		acc_new  = sum_neg ? acc_e - inc_e : acc_e + inc_e;
		sat_hi   = !sum_neg && (acc_new > AMAX_E);
		sat_lo   = sum_neg && (acc_new < AMIN_E);
		if (sat_hi) acc_next = AMAX;
		else if (sat_lo) acc_next = AMIN;
		else acc_next = acc_new[A-1:0];
	end

	// output scaling and clip
	always_comb begin
		s_sh  = s_q >>> F;
		y_fit = (s_sh <= YMAX_E) && (s_sh >= YMIN_E);
		if (y_fit) y = s_sh[W-1:0];
		else y = s_q[SW-1] ? DMIN : DMAX;
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= sample_value;
			t_q <= time_stamp;
		end
	end

	// controller state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			prev_sample_q <= '0;
			prev_time_q   <= '0;
			held_q        <= '0;
		end else if (cmd.load_out) begin
			case (cmd.kind)
				STAT_CLEARED: begin
					acc_q         <= '0;
					prev_sample_q <= '0;
					prev_time_q   <= '0;
					held_q        <= '0;
				end
				STAT_UPDATED: begin
					prev_sample_q <= x_q;
					prev_time_q   <= t_q;
					held_q        <= y;
				end
				default: begin
					held_q <= held_q;
				end
			endcase
		end else if (cmd.acc_upd) begin
			acc_q <= acc_next;
		end
	end

	// product sum and clip flag
	always_ff @(posedge clk) begin
		if (cmd.clr_sum) begin
			s_q   <= '0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.add_sum) s_q <= s_q + prod_e;
			if ((cmd.acc_upd && (inc_clip || sat_hi || sat_lo)) ||
			    (cmd.start_mul && (cmd.mul_sel == MUL_D) && deriv_sat)) begin
				sat_q <= 1'b1;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.kind)
				STAT_CLEARED: begin
					drive_q   <= '0;
					status_q  <= STAT_CLEARED;
					sat_out_q <= 1'b0;
				end
				STAT_HELD: begin
					drive_q   <= held_q;
					status_q  <= STAT_HELD;
					sat_out_q <= 1'b0;
				end
				STAT_UPDATED: begin
					drive_q   <= y;
					status_q  <= STAT_UPDATED;
					sat_out_q <= sat_q || !y_fit;
				end
				default: begin
					drive_q   <= held_q;
					status_q  <= STAT_HELD;
					sat_out_q <= 1'b0;
				end
			endcase
		end
	end

	assign drive_value = drive_q;
	assign step_status = status_q;
	assign saturated   = sat_out_q;

endmodule

// File: sim/pidt_drive_check.sv
`timescale 1ns / 100ps
module pidt_drive_check #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int ACC_WIDTH  = 64,
	parameter int ADDR_BITS  = 4,
	parameter int BUS_BITS   = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [ADDR_BITS-1:0]         paddr,
	input  logic [BUS_BITS-1:0]          pwdata,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] sample_value,
	input  logic [DATA_WIDTH-1:0]        time_stamp,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [DATA_WIDTH-1:0] drive_value,
	input  logic [1:0]                   step_status,
	input  logic                         saturated,
	output int                           mismatches,
	output int                           words_due
);
	import pidt_pkg::*;

	localparam int ADDR_SHIFT = (DATA_WIDTH > 32) ? 3 : 2;
	localparam logic [63:0] DPOS = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
	localparam logic [127:0] INC_CAP = 128'd1 << 63;
	localparam logic signed [127:0] ACC_HI = (128'sd1 <<< (ACC_WIDTH - 1)) - 128'sd1;
	localparam logic signed [127:0] ACC_LO = -(128'sd1 <<< (ACC_WIDTH - 1));
	localparam logic signed [127:0] OUT_HI = (128'sd1 <<< (DATA_WIDTH - 1)) - 128'sd1;
	localparam logic signed [127:0] OUT_LO = -(128'sd1 <<< (DATA_WIDTH - 1));

	typedef struct {
		logic signed [DATA_WIDTH-1:0] drive;
		step_status_t                 status;
		logic                         clip;
	} drive_word_t;

	// gains as seen on the config port
	logic signed [DATA_WIDTH-1:0] p_gain, i_gain, d_gain;
	// controller state
	logic signed [ACC_WIDTH-1:0]  integral;
	logic signed [DATA_WIDTH-1:0] last_sample, held_drive;
	logic [DATA_WIDTH-1:0]        last_stamp;

	drive_word_t drive_due[$];

	// expected output word for one sample, advances the state
	function automatic drive_word_t predict_drive(input logic signed [DATA_WIDTH-1:0] x,
			input logic [DATA_WIDTH-1:0] t);
		drive_word_t w;
		logic signed [63:0] xs, ps, diff, sum, deriv;
		logic [63:0] dt, mag, quo, lim;
		logic [127:0] prod, inc;
		logic signed [127:0] acc_w, gp, gi, gd, op_x, op_i, op_d, total, y_w;
		w.drive = '0;
		w.status = STAT_CLEARED;
		w.clip = 1'b0;
		// backward stamp wipes the state and answers zero
		if (t < last_stamp) begin
			integral = '0;
			last_sample = '0;
			last_stamp = '0;
			held_drive = '0;
			return w;
		end
		// equal stamp answers the held drive
		if (t == last_stamp) begin
			w.drive = held_drive;
			w.status = STAT_HELD;
			return w;
		end
		w.status = STAT_UPDATED;
		xs = x;
		ps = last_sample;
		dt = t - last_stamp;

		// derivative, truncated toward zero, clipped to the data range
		diff = xs - ps;
		mag = (diff < 0) ? -diff : diff;
		quo = (mag << FRAC_BITS) / dt;
		lim = (diff < 0) ? DPOS + 64'd1 : DPOS;
		if (quo > lim) begin
			quo = lim;
			w.clip = 1'b1;
		end
		deriv = (diff < 0) ? -$signed(quo) : $signed(quo);

		// trapezoid area, magnitude truncated, sign of the sum
		sum = xs + ps;
		mag = (sum < 0) ? -sum : sum;
		prod = 128'(mag) * 128'(dt);
		inc = prod >> (FRAC_BITS + 1);
		if (inc > INC_CAP) begin
			inc = INC_CAP;
			w.clip = 1'b1;
		end
		acc_w = integral;
		if (sum < 0)
			acc_w = acc_w - $signed(inc);
		else
			acc_w = acc_w + $signed(inc);
		if (acc_w > ACC_HI) begin
			acc_w = ACC_HI;
			w.clip = 1'b1;
		end else if (acc_w < ACC_LO) begin
			acc_w = ACC_LO;
			w.clip = 1'b1;
		end
		integral = acc_w[ACC_WIDTH-1:0];

		// weighted sum, floor shift, clip
		gp = p_gain;
		gi = i_gain;
		gd = d_gain;
		op_x = x;
		op_i = integral;
		op_d = deriv;
		total = gp * op_x + gi * op_i + gd * op_d;
		y_w = total >>> FRAC_BITS;
		if (y_w > OUT_HI) begin
			y_w = OUT_HI;
			w.clip = 1'b1;
		end else if (y_w < OUT_LO) begin
			y_w = OUT_LO;
			w.clip = 1'b1;
		end
		w.drive = y_w[DATA_WIDTH-1:0];

		last_sample = x;
		last_stamp = t;
		held_drive = w.drive;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t got, want;
		if (!arst_n) begin
			p_gain = 1 << FRAC_BITS;
			i_gain = '0;
			d_gain = '0;
			integral = '0;
			last_sample = '0;
			last_stamp = '0;
			held_drive = '0;
			drive_due.delete();
			mismatches = 0;
			words_due <= 0;
		end else begin
			// gain writes, unknown indexes fall through
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr >> ADDR_SHIFT))
					REG_P_GAIN: p_gain = pwdata[DATA_WIDTH-1:0];
					REG_I_GAIN: i_gain = pwdata[DATA_WIDTH-1:0];
					REG_D_GAIN: d_gain = pwdata[DATA_WIDTH-1:0];
					default: ;
				endcase
			end

			// accepted sample word
			if (in_valid && !in_stall)
				drive_due.push_back(predict_drive(sample_value, time_stamp));

			// accepted drive word against the oldest expectation
			if (out_valid && !out_stall) begin
				got.drive = drive_value;
				got.status = step_status_t'(step_status);
				got.clip = saturated;
				if (drive_due.size() == 0) begin
					$display("%0t: drive word expected none got drive %0d status %0d clip %0b",
						$time, got.drive, got.status, got.clip);
					mismatches++;
				end else begin
					want = drive_due.pop_front();
					if (got.drive !== want.drive) begin
						$display("%0t: drive_value expected %0d got %0d",
							$time, want.drive, got.drive);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$display("%0t: step_status expected %0d got %0d",
							$time, want.status, got.status);
						mismatches++;
					end
					if (got.clip !== want.clip) begin
						$display("%0t: saturated expected %0b got %0b",
							$time, want.clip, got.clip);
						mismatches++;
					end
				end
			end
			words_due <= drive_due.size();
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
module tb;
	import pidt_pkg::*;

	localparam int DW = 32;
	localparam reg_idx_t REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] sample_value = '0;
	logic [DW-1:0] time_stamp = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] drive_value;
	logic [1:0] step_status;
	logic saturated;

	int fail_cnt;
	int pending;
	bit calm = 1'b0;
	int unsigned idle_pct = 20;
	// what the block holds as its previous sample and stamp
	logic signed [DW-1:0] sample_now = '0;
	logic [DW-1:0] stamp_now = '0;

	pid_controller_trapezoid u_dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .sample_value, .time_stamp,
		.out_valid, .out_stall, .drive_value, .step_status, .saturated
	);

	pidt_drive_check u_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .sample_value, .time_stamp,
		.out_valid, .out_stall, .drive_value, .step_status, .saturated,
		.mismatches(fail_cnt), .words_due(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// output back-pressure in bursts
	always begin
		@(posedge clk);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		out_stall <= 1'b0;
	end

	function automatic int spread(input int unsigned span);
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	// sample: extremes, full range, moderate, or a small step from the last one
	function automatic logic signed [DW-1:0] next_sample();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return '0;
				3: return -1;
				default: return 1;
			endcase
		end
		if (pick < 20)
			return $urandom;
		if (pick < 50)
			return spread(1 << 20);
		return sample_now + spread(4096);
	endfunction

	// stamp: mostly forward steps, some equal, some backward, some noise
	function automatic logic [DW-1:0] next_stamp();
		int unsigned pick;
		logic [DW-1:0] step;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return stamp_now;
		if (pick < 13)
			return (stamp_now == 0) ? $urandom : $urandom_range(0, stamp_now - 1);
		if (pick < 20)
			return $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: step = $urandom_range(1, 32'h3FF);
			4, 5, 6: step = $urandom_range(32'h400, 32'h3_FFFF);
			7, 8: step = $urandom_range(1, 32'hFF_FFFF);
			default: step = $urandom | 32'd1;
		endcase
		return stamp_now + step;
	endfunction

	// one sample word, with an optional gap in front
	task automatic send_sample(input logic signed [DW-1:0] x, input logic [DW-1:0] t);
		int unsigned gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_value <= x;
		time_stamp <= t;
		do @(posedge clk); while (in_stall);
		sample_now = x;
		if (t < stamp_now) begin
			stamp_now = '0;
			sample_now = '0;
		end else begin
			stamp_now = t;
		end
	endtask

	// register write once every drive word is back
	task automatic write_gain(input reg_idx_t idx, input logic [31:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_gains(input int unsigned style);
		logic [31:0] g [3];
		case (style)
			0: begin
				g[0] = spread(1 << 18);
				g[1] = spread(1 << 15);
				g[2] = spread(1 << 15);
			end
			1: foreach (g[k]) g[k] = $urandom;
			2: foreach (g[k]) g[k] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			3: begin
				g[0] = 32'h0001_0000;
				g[1] = spread(1 << 8);
				g[2] = '0;
			end
			default: foreach (g[k]) g[k] = '0;
		endcase
		write_gain(REG_P_GAIN, g[0]);
		write_gain(REG_I_GAIN, g[1]);
		write_gain(REG_D_GAIN, g[2]);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: equal stamp at start, tiny and full-range steps, backward
		send_sample(0, 0);
		send_sample(32'sh7FFF_FFFF, 1);
		send_sample(32'sh8000_0000, 2);
		send_sample(32'sh8000_0000, 2);
		send_sample(5, 1);
		send_sample(32'sh8000_0000, 32'hFFFF_FFFF);
		send_sample(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(0, 0);

		// extreme gains, plus a write to an unused index
		write_gain(REG_P_GAIN, 32'h7FFF_FFFF);
		write_gain(REG_I_GAIN, 32'h7FFF_FFFF);
		write_gain(REG_D_GAIN, 32'h8000_0000);
		write_gain(REG_SPARE, 32'h1234_5678);
		send_sample(32'sh7FFF_FFFF, 32'h100);
		send_sample(32'sh7FFF_FFFF, 32'h1_0000);
		send_sample(32'sh8000_0000, 32'h2_0000);
		send_sample(-1, 32'h2_0000);
		send_sample(1, 32'h1_0000);
		send_sample(32'sh7FFF_FFFF, 32'hFFFF_FFFF);

		// opposite extremes, derivative dominated
		write_gain(REG_P_GAIN, 32'h8000_0000);
		write_gain(REG_I_GAIN, 32'h0);
		write_gain(REG_D_GAIN, 32'h7FFF_FFFF);
		send_sample(32'sh8000_0000, 1);
		send_sample(100, 2);
		send_sample(-100, 3);
		send_sample(65536, 32'h1_0003);

		// ordinary gains: 1.0, 0.5, 0.25
		write_gain(REG_P_GAIN, 32'h0001_0000);
		write_gain(REG_I_GAIN, 32'h0000_8000);
		write_gain(REG_D_GAIN, 32'h0000_4000);
		send_sample(65536, 32'h2_0003);
		send_sample(131072, 32'h3_0003);
		send_sample(-65536, 32'h3_8003);
		send_sample(0, 32'h3_8003);

		// random phases, each with its own gains and idle rate, last one calm
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph == 11);
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 15;
				2: idle_pct = 40;
				default: idle_pct = 70;
			endcase
			set_gains(ph % 5);
			repeat (153) send_sample(next_sample(), next_stamp());
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_cnt == 0)
			$display("pid_controller_trapezoid test passed");
		else
			$display("pid_controller_trapezoid test failed");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("pid_controller_trapezoid test failed");
		$finish;
	end

endmodule
